/* hw/rtl/thc_pkg.sv */
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants
// Calibration register set, register indexes and fixed constants of the
// temperature / humidity compensation pipeline.
// ----------------------------------------------------------------------------
package thc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes on the cfg port
  localparam logic [CFG_IDX_W-1:0] REG_T1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T2  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T3  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H3  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_H45 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_H6  = 3'd7;

  // datapath depth: one valid bit per stage
  localparam int unsigned N_STAGES = 15;

  localparam logic [31:0] T_FINE_OFS = 32'd76800;
  localparam logic [31:0] HUM_MAX    = 32'd419430400;
  localparam logic [31:0] H_RND_A    = 32'd16384;
  localparam logic [31:0] H_OFS_B1   = 32'd2097152;
  localparam logic [31:0] H_RND_B2   = 32'd8192;
  localparam logic [31:0] H_OFS_BM2  = 32'd32768;
  localparam logic [31:0] T_RND      = 32'd128;
  // ceil(2^37 / 100): exact quotient for any 32-bit unsigned dividend
  localparam logic [31:0] RECIP100   = 32'd1374389535;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [23:0] h45;
    logic [7:0]  h6;
  } cal_t;

endpackage

/* hw/rtl/temp_humidity_compensation.sv */
// ----------------------------------------------------------------------------
// temp_humidity_compensation: sensor integer compensation, stream in/out
// Turns raw temperature and humidity readings into compensated values
// using calibration coefficients from the cfg port.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* carries one reading per item: raw temperature and raw humidity.
//  - out_* returns one item per reading: temperature in 0.01 degC and whole
//    degrees (toward zero), humidity in Q7.10 percent and whole percent.
//  - cfg_*: plain write port, eight calibration registers (index 0..7).
//    Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled; the
//   pipeline is fifteen stages deep, set by the chain of 32-bit
//   multiplies in the humidity formula.
// Stall: all stages advance on one enable. While out_tready is low with a
//   result waiting, the pipeline holds and in_tready drops; nothing is lost
//   or repeated. Bubbles in flight do not block input.
// Reset: clears every valid bit and all calibration registers to zero.
// ----------------------------------------------------------------------------
module temp_humidity_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,  // [19:0] raw_temperature,
                                                    // [35:20] raw_humidity
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [87:0]                    out_tdata, // [31:0] temp_hundredths,
                                                    // [57:32] temp_whole,
                                                    // [74:58] humidity_q10,
                                                    // [81:75] humidity_whole
  // configuration
  input  logic                           cfg_we,
  input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import thc_pkg::*;

  cal_t                cal_r;
  logic [N_STAGES-1:0] vld_r, vld_nxt;
  logic                adv;

  logic signed [31:0]  temp_hundredths;
  logic signed [25:0]  temp_whole;
  logic [16:0]         humidity_q10;
  logic [6:0]          humidity_whole;

  // calibration registers; each keeps only the low bits of its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_T1:  cal_r.t1  <= cfg_wdata[15:0];
        REG_T2:  cal_r.t2  <= cfg_wdata[15:0];
        REG_T3:  cal_r.t3  <= cfg_wdata[15:0];
        REG_H1:  cal_r.h1  <= cfg_wdata[7:0];
        REG_H2:  cal_r.h2  <= cfg_wdata[15:0];
        REG_H3:  cal_r.h3  <= cfg_wdata[7:0];
        REG_H45: cal_r.h45 <= cfg_wdata;
        REG_H6:  cal_r.h6  <= cfg_wdata[7:0];
        default: cal_r     <= cal_r;
      endcase
    end
  end

  // pipeline moves when the output stage is empty or being taken
  assign adv       = ~vld_r[N_STAGES-1] | out_tready;
  assign in_tready = adv;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[N_STAGES-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  thc_datapath u_dp (
    .clk             (clk),
    .en              (adv),
    .raw_temperature (in_tdata[19:0]),
    .raw_humidity    (in_tdata[35:20]),
    .cal             (cal_r),
    .temp_hundredths (temp_hundredths),
    .temp_whole      (temp_whole),
    .humidity_q10    (humidity_q10),
    .humidity_whole  (humidity_whole)
  );

  assign out_tvalid = vld_r[N_STAGES-1];
  assign out_tdata  = {6'd0, humidity_whole, humidity_q10, temp_whole, temp_hundredths};

endmodule

/* hw/rtl/thc_datapath.sv */
// ----------------------------------------------------------------------------
// thc_datapath: compensation arithmetic
// Fifteen register stages, all advancing on one enable. 32-bit wrap (the
// reciprocal product is 64-bit) and arithmetic right shifts throughout.
// ----------------------------------------------------------------------------
module thc_datapath (
  input  logic                clk,
  input  logic                en,
  input  logic [19:0]         raw_temperature,
  input  logic [15:0]         raw_humidity,
  input  thc_pkg::cal_t       cal,
  output logic signed [31:0]  temp_hundredths,
  output logic signed [25:0]  temp_whole,
  output logic [16:0]         humidity_q10,
  output logic [6:0]          humidity_whole
);
  import thc_pkg::*;

  // zero- and sign-extended coefficients
  logic [31:0] t1z, t2s, t3s, h1z, h2s, h3z, h6s;
  logic [11:0] h4_12, h5_12;
  logic [31:0] h5s;

  assign t1z   = {16'd0, cal.t1};
  assign t2s   = {{16{cal.t2[15]}}, cal.t2};
  assign t3s   = {{16{cal.t3[15]}}, cal.t3};
  assign h1z   = {24'd0, cal.h1};
  assign h2s   = {{16{cal.h2[15]}}, cal.h2};
  assign h3z   = {24'd0, cal.h3};
  assign h6s   = {{24{cal.h6[7]}}, cal.h6};
  assign h4_12 = {cal.h45[7:0], cal.h45[11:8]};
  assign h5_12 = {cal.h45[23:16], cal.h45[15:12]};
  assign h5s   = {{20{h5_12[11]}}, h5_12};

  // stage registers
  logic [31:0] s1_x_r, s1_d_r;
  logic [31:0] s2_p1_r, s2_dd_r;
  logic [31:0] s3_var1_r, s3_q_r;
  logic [31:0] s4_tfine_r;
  logic [31:0] s5_v_r;
  logic        s6_neg_r;
  logic [31:0] s6_mag_r, s6_pa_r, s6_pb_r, s6_pc_r;
  logic        s7_neg_r;
  logic [63:0] s7_prod_r;
  logic [31:0] s7_bm1_r, s7_bm2_r;
  logic [31:0] s8_b0_r;
  logic [31:0] s9_b1_r;
  logic [31:0] s10_b2_r;
  logic [31:0] s11_b_r;
  logic [31:0] s12_v_r;
  logic [31:0] s13_v_r, s13_ss_r;
  logic [31:0] s14_v_r, s14_r_r;
  logic [16:0] s15_hq_r;
  logic [6:0]  s15_hw_r;

  // carried values, one register per stage
  logic [15:0] adch_r  [1:6];
  logic [31:0] temp_r  [5:15];
  logic [25:0] whole_r [8:15];
  logic [31:0] a_r     [7:11];

  // combinational helpers
  logic [31:0] tf5;
  logic [31:0] temp_c;
  logic [31:0] a_sum;
  logic [26:0] q100;
  logic [31:0] s13_s;
  logic [31:0] v2;
  logic [31:0] v2_cl;

  assign tf5    = (s4_tfine_r << 2) + s4_tfine_r + T_RND;
  assign temp_c = 32'($signed(tf5) >>> 8);
  assign a_sum  = {2'd0, adch_r[6], 14'd0} - {h4_12, 20'd0} - s6_pa_r + H_RND_A;
  assign q100   = s7_prod_r[63:37];
  assign s13_s  = 32'($signed(s12_v_r) >>> 15);
  assign v2     = s14_v_r - 32'($signed(s14_r_r) >>> 4);

  // clamp to 0..HUM_MAX
  always_comb begin
    if (v2[31]) begin
      v2_cl = 32'd0;
    end else if (v2 > HUM_MAX) begin
      v2_cl = HUM_MAX;
    end else begin
      v2_cl = v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature
      s1_x_r     <= {15'd0, raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
      s1_d_r     <= {16'd0, raw_temperature[19:4]} - t1z;
      adch_r[1]  <= raw_humidity;
      s2_p1_r    <= s1_x_r * t2s;
      s2_dd_r    <= s1_d_r * s1_d_r;
      s3_var1_r  <= 32'($signed(s2_p1_r) >>> 11);
      s3_q_r     <= 32'($signed(s2_dd_r) >>> 12) * t3s;
      s4_tfine_r <= s3_var1_r + 32'($signed(s3_q_r) >>> 14);
      temp_r[5]  <= temp_c;
      s5_v_r     <= s4_tfine_r - T_FINE_OFS;

      // whole degrees: magnitude, reciprocal multiply, sign restore
      s6_neg_r   <= temp_r[5][31];
      s6_mag_r   <= temp_r[5][31] ? (32'd0 - temp_r[5]) : temp_r[5];
      s7_neg_r   <= s6_neg_r;
      s7_prod_r  <= {32'd0, s6_mag_r} * {32'd0, RECIP100};
      whole_r[8] <= s7_neg_r ? 26'(~q100 + 27'd1) : q100[25:0];

      // humidity
      s6_pa_r    <= h5s * s5_v_r;
      s6_pb_r    <= s5_v_r * h6s;
      s6_pc_r    <= s5_v_r * h3z;
      a_r[7]     <= 32'($signed(a_sum) >>> 15);
      s7_bm1_r   <= 32'($signed(s6_pb_r) >>> 10);
      s7_bm2_r   <= 32'($signed(s6_pc_r) >>> 11) + H_OFS_BM2;
      s8_b0_r    <= s7_bm1_r * s7_bm2_r;
      s9_b1_r    <= 32'($signed(s8_b0_r) >>> 10) + H_OFS_B1;
      s10_b2_r   <= s9_b1_r * h2s;
      s11_b_r    <= 32'($signed(s10_b2_r + H_RND_B2) >>> 14);
      s12_v_r    <= a_r[11] * s11_b_r;
      s13_v_r    <= s12_v_r;
      s13_ss_r   <= s13_s * s13_s;
      s14_v_r    <= s13_v_r;
      s14_r_r    <= 32'($signed(s13_ss_r) >>> 7) * h1z;
      s15_hq_r   <= v2_cl[28:12];
      s15_hw_r   <= v2_cl[28:22];

      for (int i = 2; i <= 6; i++) begin
        adch_r[i] <= adch_r[i-1];
      end
      for (int i = 6; i <= 15; i++) begin
        temp_r[i] <= temp_r[i-1];
      end
      for (int i = 9; i <= 15; i++) begin
        whole_r[i] <= whole_r[i-1];
      end
      for (int i = 8; i <= 11; i++) begin
        a_r[i] <= a_r[i-1];
      end
    end
  end

  assign temp_hundredths = temp_r[15];
  assign temp_whole      = whole_r[15];
  assign humidity_q10    = s15_hq_r;
  assign humidity_whole  = s15_hw_r;

endmodule
